### src/leb128_encoder_core_macros.svh
// Assertion macros used by the LEB128 encoder back end.
`ifndef LEB128_ENCODER_CORE_MACROS_SVH
`define LEB128_ENCODER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LEB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define LEB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/leb_pkg.sv
// Shared constants and types for the LEB128 encoder.
package leb_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int GROUP_BITS      = 7;

	localparam logic MODE_UNSIGNED = 1'b0;
	localparam logic MODE_SIGNED   = 1'b1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic full;
		logic empty;
	} leb_qstat_t;

endpackage

### src/leb_front.sv
// Front end: accept input words, clamp them by mode and push them to the queue.
module leb_front
	import leb_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   opcode,
	input  leb_qstat_t             qstat,
	output logic                   push,
	output logic [VALUE_WIDTH-1:0] push_value,
	output logic                   push_mode
);

	logic clamp;

	assign req_stall = qstat.full;
	assign push      = req_valid && !qstat.full;

	// Unsigned mode: negative input encodes as zero.
	assign clamp      = (opcode == MODE_UNSIGNED) && value[VALUE_WIDTH-1];
	assign push_value = clamp ? '0 : value;
	assign push_mode  = opcode;

endmodule

### src/leb_fifo.sv
// Short queue between the front end and the byte emitter.
module leb_fifo
	import leb_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [VALUE_WIDTH-1:0] push_value,
	input  logic                   push_mode,
	input  logic                   pop,
	output logic [VALUE_WIDTH-1:0] pop_value,
	output logic                   pop_mode,
	output leb_qstat_t             qstat
);

	logic [VALUE_WIDTH-1:0] value_mem [QDEPTH];
	logic                   mode_mem  [QDEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]      count_q;
	logic                   do_push, do_pop;

	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;

	assign pop_value = value_mem[rd_ptr_q];
	assign pop_mode  = mode_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			value_mem[wr_ptr_q] <= push_value;
			mode_mem[wr_ptr_q]  <= push_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/leb_back.sv
// Back end: split one queued value into LEB128 bytes, one per cycle while the output is not stalled.
`include "leb128_encoder_core_macros.svh"
module leb_back
	import leb_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  leb_qstat_t             qstat,
	input  logic [VALUE_WIDTH-1:0] pop_value,
	input  logic                   pop_mode,
	output logic                   pop,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [7:0]             out_byte,
	output logic                   last
);

	logic signed [VALUE_WIDTH-1:0] rem_q, rem_next;
	logic                          sgn_q, busy_q;
	logic                          ovalid_q, last_q;
	logic [7:0]                    byte_q;
	logic [GROUP_BITS-1:0]         grp;
	logic                          out_free, emit, done;

	assign grp      = rem_q[GROUP_BITS-1:0];
	assign rem_next = rem_q >>> GROUP_BITS;

	// Signed mode ends when the remainder is pure sign that matches bit 6.
	always_comb begin
		if (sgn_q == MODE_SIGNED) begin
			done = ((rem_next == '0) && !grp[GROUP_BITS-1]) ||
			       ((rem_next == '1) && grp[GROUP_BITS-1]);
		end else begin
			done = (rem_next == '0);
		end
	end

	assign out_free = !ovalid_q || !rsp_stall;
	assign emit     = busy_q && out_free;
	assign pop      = !qstat.empty && (!busy_q || (emit && done));

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= pop_value;
			sgn_q <= pop_mode;
		end else if (emit) begin
			rem_q <= rem_next;
		end
		if (emit) begin
			byte_q <= {!done, grp};
			last_q <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && done) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (!rsp_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = ovalid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

	`LEB_ASSERT_NEXT(a_rem_hold, clk, arst_n, busy_q && !out_free, $stable(rem_q), "remainder moved while output blocked")
	`LEB_ASSERT_SAME(a_more_flag, clk, arst_n, ovalid_q, byte_q[7] != last_q, "continuation bit disagrees with last")
	`LEB_ASSERT_SAME(a_unsigned_pos, clk, arst_n, busy_q && (sgn_q == MODE_UNSIGNED), !rem_q[VALUE_WIDTH-1], "unsigned remainder went negative")

endmodule

### src/leb128_encoder_core.sv
// Top level of the LEB128 encoder: front end, queue and byte emitter.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one word: value and
//   opcode (0 = unsigned, negative clamped to zero; 1 = signed).
//   Response channel (rsp_valid / rsp_stall) carries one encoded byte per
//   transfer in out_byte, low groups first, bit 7 set while more bytes follow;
//   last marks the final byte of a value.
//   A value yields 1 to ceil(VALUE_WIDTH/7) bytes (1 to 5 at 32 bits).
//   The first byte of a request passes through the queue entry, the emitter's
//   remainder register and its single output register before it shows on
//   rsp_valid. The emitter sends one byte per cycle while rsp_stall is low.
//   Back-to-back values follow with no gap while the two-entry queue holds
//   work.
//   A stalled response holds its byte and the emitter; the front keeps
//   accepting requests until the queue fills, then raises req_stall.
//   Reset empties the queue, drops the emitter's current value and clears
//   rsp_valid.
module leb128_encoder_core
	import leb_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   opcode,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [7:0]             out_byte,
	output logic                   last
);

	leb_qstat_t             qstat;
	logic                   push, pop;
	logic [VALUE_WIDTH-1:0] push_value, pop_value;
	logic                   push_mode, pop_mode;

	// Accept and clamp by mode.
	leb_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.value      (value),
		.opcode     (opcode),
		.qstat      (qstat),
		.push       (push),
		.push_value (push_value),
		.push_mode  (push_mode)
	);

	// Decouple the two sides so each can stall on its own.
	leb_fifo #(.VALUE_WIDTH(VALUE_WIDTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_value (push_value),
		.push_mode  (push_mode),
		.pop        (pop),
		.pop_value  (pop_value),
		.pop_mode   (pop_mode),
		.qstat      (qstat)
	);

	// Shift out seven bits per cycle, while the output is not stalled, until the stop rule fires.
	leb_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_value (pop_value),
		.pop_mode  (pop_mode),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
